// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file i2a_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/i2a_pkg.sv =====
// shared types, constants and the digit-to-ascii function
// used by all modules of integer_to_ascii_formatter
`default_nettype none

package i2a_pkg;

    localparam int unsigned DEF_MAX_PRECISION = 40;
    localparam int unsigned VAL_W             = 64;
    localparam int unsigned NDEC              = 20;
    localparam int unsigned NDIG              = 22;
    localparam int unsigned DIG_BITS          = NDIG * 4;
    localparam int unsigned ND_W              = $clog2(NDIG + 1);
    localparam int unsigned CNT_W             = $clog2(VAL_W + 1);

    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_LO_A  = 8'h61;
    localparam logic [7:0] ASC_UP_A  = 8'h41;

    typedef enum logic [2:0] {
        OP_CHAR   = 3'd0,
        OP_DEC    = 3'd1,
        OP_OCT    = 3'd2,
        OP_HEX_LO = 3'd3,
        OP_HEX_UP = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic ready;
        logic take;
        logic copy;
        logic scan;
        logic emit;
        logic advance;
    } ctrl_t;

    typedef struct packed {
        logic in_char;
        logic in_dec;
        logic conv_done;
        logic scan_done;
        logic last;
    } stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? ASC_UP_A : ASC_LO_A;
        if (d < 4'd10) begin
            digit_char = ASC_ZERO + {4'b0, d};
        end else begin
            digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i2a_bcd.sv =====
// bit-serial binary to bcd converter, one shift-and-adjust step per cycle
// depends on i2a_pkg
`default_nettype none

module i2a_bcd import i2a_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic [VAL_W-1:0]     value,
    input  wire logic [CNT_W-1:0]     nbits,
    output logic      [NDEC*4-1:0]    bcd,
    output logic                      done
);

    logic [VAL_W-1:0]  sh_reg, sh_next;
    logic [NDEC*4-1:0] bcd_reg, bcd_next, adj;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        for (int k = 0; k < NDEC; k++) begin
            if (bcd_reg[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    always_comb begin
        sh_next  = sh_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (load) begin
            sh_next  = value;
            bcd_next = '0;
            cnt_next = nbits;
        end else if (cnt_reg != '0) begin
            bcd_next = {adj[NDEC*4-2:0], sh_reg[VAL_W-1]};
            sh_next  = {sh_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign bcd  = bcd_reg;
    assign done = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== hdl/i2a_ctrl.sv =====
// sequencer: idle, decimal conversion, leading-zero scan, character output
// depends on i2a_pkg
`default_nettype none

module i2a_ctrl import i2a_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (stat.in_char) begin
                        state_next = ST_EMIT;
                    end else if (stat.in_dec) begin
                        state_next = ST_CONV;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CONV: begin
                if (stat.conv_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_ready && stat.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl.ready = 1'b1;
                ctrl.take  = s_valid;
            end
            ST_CONV: begin
                ctrl.copy = stat.conv_done;
            end
            ST_SCAN: begin
                ctrl.scan = 1'b1;
            end
            ST_EMIT: begin
                ctrl.emit    = 1'b1;
                ctrl.advance = m_ready;
            end
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// top level: item capture, digit shift line, padding and character output
// depends on i2a_pkg, i2a_bcd, i2a_ctrl
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+----
//  input   | s_valid s_ready s_number s_is_wide s_twos_comp      | in
//          | s_opcode s_min_digits                              |
//  result  | m_valid m_ready m_char_code m_total_length m_last  | out
//
// one item at a time; s_ready is high only while idle
// character kind: the item is taken, then 1 character
// hex/octal: the item is taken, then a leading-zero scan over up to 22 digits, then the characters
// decimal: adds a 32-bit or 64-bit conversion in the bit-serial bcd converter
// a stalled m_ready holds the current character; synchronous active-low reset to idle
`default_nettype none

module integer_to_ascii_formatter import i2a_pkg::*; #(
    parameter int unsigned MAX_PRECISION = DEF_MAX_PRECISION
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_number,
    input  wire logic        s_is_wide,
    input  wire logic        s_twos_comp,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [5:0]  s_min_digits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_char_code,
    output logic [5:0]       m_total_length,
    output logic             m_last
);

    localparam int unsigned PREC_W  = $clog2(MAX_PRECISION + 1);
    localparam int unsigned LEN_MAX = (MAX_PRECISION > NDIG) ? MAX_PRECISION + 1 : NDIG + 1;
    localparam int unsigned LEN_W   = $clog2(LEN_MAX + 1);

    ctrl_t ctrl;
    stat_t stat;

    logic              in_char, in_dec, in_oct, in_upper;
    logic [VAL_W-1:0]  val, negv, mag, bcd_val;
    logic [DIG_BITS-1:0] mag_ext, bcd_ext;
    logic              sign_bit, neg;
    logic [CNT_W-1:0]  nbits;
    logic [PREC_W-1:0] prec_in;
    logic [NDEC*4-1:0] bcd;
    logic              conv_done;
    logic [3:0]        dig_in [NDIG];
    logic [3:0]        dig_bcd [NDIG];
    logic [3:0]        dig_shift [NDIG];

    logic [3:0]        dig_reg [NDIG];
    logic [3:0]        dig_next [NDIG];
    logic [ND_W-1:0]   nd_reg, nd_next;
    logic [PREC_W-1:0] prec_reg, prec_next;
    logic [PREC_W-1:0] pad_reg, pad_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              pre_reg, pre_next;
    logic [7:0]        char_reg, char_next;
    logic              is_char_reg, is_char_next;
    logic              is_dec_reg, is_dec_next;
    logic              is_oct_reg, is_oct_next;
    logic              upper_reg, upper_next;
    logic              neg_reg, neg_next;

    logic              scan_done;
    logic [PREC_W-1:0] pad_calc;
    logic              pre_calc;
    logic [LEN_W-1:0]  total_calc;

    // opcode decode, undefined codes format as decimal
    always_comb begin
        in_char  = 1'b0;
        in_dec   = 1'b0;
        in_oct   = 1'b0;
        in_upper = 1'b0;
        case (s_opcode)
            OP_CHAR:   in_char  = 1'b1;
            OP_DEC:    in_dec   = 1'b1;
            OP_OCT:    in_oct   = 1'b1;
            OP_HEX_LO: in_upper = 1'b0;
            OP_HEX_UP: in_upper = 1'b1;
            default:   in_dec   = 1'b1;
        endcase
    end

    // magnitude of the incoming value, plus the bcd input, bit count and clamped precision
    always_comb begin
        val      = s_is_wide ? s_number : {32'b0, s_number[31:0]};
        sign_bit = s_is_wide ? s_number[63] : s_number[31];
        neg      = in_dec && s_twos_comp && sign_bit;
        negv     = ~val + 64'd1;
        if (neg) begin
            mag = s_is_wide ? negv : {32'b0, negv[31:0]};
        end else begin
            mag = val;
        end
        mag_ext = {{(DIG_BITS - VAL_W){1'b0}}, mag};
        bcd_val = s_is_wide ? mag : {mag[31:0], 32'b0};
        nbits   = s_is_wide ? CNT_W'(VAL_W) : CNT_W'(VAL_W / 2);
        if (s_min_digits > MAX_PRECISION) begin
            prec_in = PREC_W'(MAX_PRECISION);
        end else begin
            prec_in = PREC_W'(s_min_digits);
        end
    end

    // digit line images, index 0 is the most significant digit
    always_comb begin
        bcd_ext = {{(DIG_BITS - NDEC*4){1'b0}}, bcd};
        for (int i = 0; i < NDIG; i++) begin
            if (in_oct) begin
                dig_in[i] = {1'b0, mag_ext[3*(NDIG-1-i) +: 3]};
            end else begin
                dig_in[i] = mag_ext[4*(NDIG-1-i) +: 4];
            end
            dig_bcd[i] = bcd_ext[4*(NDIG-1-i) +: 4];
        end
        for (int i = 0; i < NDIG - 1; i++) begin
            dig_shift[i] = dig_reg[i+1];
        end
        dig_shift[NDIG-1] = 4'd0;
    end

    i2a_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (ctrl.take && in_dec),
        .value   (bcd_val),
        .nbits   (nbits),
        .bcd     (bcd),
        .done    (conv_done)
    );

    // text layout once the leading digit is found
    always_comb begin
        scan_done = (dig_reg[0] != 4'd0) || (nd_reg == ND_W'(1));
        if (prec_reg > nd_reg) begin
            pad_calc = PREC_W'(prec_reg - nd_reg);
        end else begin
            pad_calc = '0;
        end
        if (is_dec_reg) begin
            pre_calc = neg_reg;
        end else begin
            pre_calc = is_oct_reg && (pad_calc == '0);
        end
        total_calc = LEN_W'(pre_calc) + LEN_W'(pad_calc) + LEN_W'(nd_reg);
    end

    always_comb begin
        dig_next     = dig_reg;
        nd_next      = nd_reg;
        prec_next    = prec_reg;
        pad_next     = pad_reg;
        total_next   = total_reg;
        rem_next     = rem_reg;
        pre_next     = pre_reg;
        char_next    = char_reg;
        is_char_next = is_char_reg;
        is_dec_next  = is_dec_reg;
        is_oct_next  = is_oct_reg;
        upper_next   = upper_reg;
        neg_next     = neg_reg;
        if (ctrl.take) begin
            dig_next     = dig_in;
            nd_next      = ND_W'(NDIG);
            prec_next    = prec_in;
            char_next    = s_number[7:0];
            is_char_next = in_char;
            is_dec_next  = in_dec;
            is_oct_next  = in_oct;
            upper_next   = in_upper;
            neg_next     = neg;
            pad_next     = '0;
            pre_next     = 1'b0;
            total_next   = LEN_W'(1);
            rem_next     = LEN_W'(1);
        end
        if (ctrl.copy) begin
            dig_next = dig_bcd;
        end
        if (ctrl.scan) begin
            if (!scan_done) begin
                dig_next = dig_shift;
                nd_next  = nd_reg - 1'b1;
            end else begin
                pad_next   = pad_calc;
                pre_next   = pre_calc;
                total_next = total_calc;
                rem_next   = total_calc;
            end
        end
        if (ctrl.advance) begin
            rem_next = rem_reg - 1'b1;
            if (pre_reg) begin
                pre_next = 1'b0;
            end else if (pad_reg != '0) begin
                pad_next = pad_reg - 1'b1;
            end else begin
                dig_next = dig_shift;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg     <= dig_next;
        nd_reg      <= nd_next;
        prec_reg    <= prec_next;
        pad_reg     <= pad_next;
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        pre_reg     <= pre_next;
        char_reg    <= char_next;
        is_char_reg <= is_char_next;
        is_dec_reg  <= is_dec_next;
        is_oct_reg  <= is_oct_next;
        upper_reg   <= upper_next;
        neg_reg     <= neg_next;
    end

    assign stat.in_char   = in_char;
    assign stat.in_dec    = in_dec;
    assign stat.conv_done = conv_done;
    assign stat.scan_done = scan_done;
    assign stat.last      = (rem_reg == LEN_W'(1));

    i2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    always_comb begin
        if (is_char_reg) begin
            m_char_code = char_reg;
        end else if (pre_reg) begin
            m_char_code = is_dec_reg ? ASC_MINUS : ASC_ZERO;
        end else if (pad_reg != '0) begin
            m_char_code = ASC_ZERO;
        end else begin
            m_char_code = digit_char(dig_reg[0], upper_reg);
        end
    end

    assign s_ready        = ctrl.ready;
    assign m_valid        = ctrl.emit;
    assign m_total_length = 6'(total_reg);
    assign m_last         = stat.last;

endmodule

`default_nettype wire

// ===== hdl/i2a_checker.sv =====
// port-level checks for integer_to_ascii_formatter and its bind
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module i2a_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_char_code,
    input wire logic [5:0]  m_total_length,
    input wire logic        m_last
);

    // stalled item holds
    `ASSERT_RST(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_total_length) && $stable(m_last), "result item changed while stalled")

    // no new item taken while characters are going out
    `ASSERT_RST(a_one_item, aclk, aresetn, s_ready |-> !m_valid, "input ready during output")

    // last character returns the block to idle
    `ASSERT_RST(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last |=> s_ready && !m_valid, "not idle after last character")

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);

`default_nettype wire

// ===== test/tb_integer_to_ascii_formatter.sv =====
`timescale 1ns / 100ps
// testbench for integer_to_ascii_formatter: a directed table, then random items
// in three idling phases, checked against a local formatter model
// depends on i2a_pkg and the integer_to_ascii_formatter rtl

module tb_integer_to_ascii_formatter;
    import i2a_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    localparam string LOWER_GLYPHS = "0123456789abcdef";
    localparam string UPPER_GLYPHS = "0123456789ABCDEF";

    localparam int RANDOM_PER_PHASE = 42;
    localparam int HOLDOFF_CYCLES   = 400;
    localparam int DRAIN_CYCLES     = 200;
    localparam int CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic [63:0] number;
        logic        is_wide;
        logic        twos_comp;
        logic [2:0]  opcode;
        logic [5:0]  min_digits;
    } number_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic [5:0] total_length;
        logic       last;
    } char_item_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [63:0] s_number       = '0;
    logic        s_is_wide      = 1'b0;
    logic        s_twos_comp    = 1'b0;
    logic [2:0]  s_opcode       = OP_CHAR;
    logic [5:0]  s_min_digits   = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_char_code;
    logic [5:0]  m_total_length;
    logic        m_last;

    char_item_t   pending_chars[$];
    number_item_t table_items[$];
    string        table_text[$];

    int sender_idle_pct   = 20;
    int receiver_idle_pct = 76;
    int holdoff_request   = 0;
    int holdoff_seen      = 0;
    int holdoff_left      = 0;
    int mismatches        = 0;
    int cycle_count       = 0;
    char_item_t want;

    integer_to_ascii_formatter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_number       (s_number),
        .s_is_wide      (s_is_wide),
        .s_twos_comp    (s_twos_comp),
        .s_opcode       (s_opcode),
        .s_min_digits   (s_min_digits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_code    (m_char_code),
        .m_total_length (m_total_length),
        .m_last         (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void format_number(input number_item_t it, output logic [7:0] chars[$]);
        logic [7:0]  digits[$];
        logic [63:0] v;
        int unsigned prec;
        int unsigned base;
        logic        neg;
        logic        upper;
        chars = {};
        prec = (it.min_digits > DEF_MAX_PRECISION) ? DEF_MAX_PRECISION : it.min_digits;
        v = it.is_wide ? it.number : {32'd0, it.number[31:0]};
        case (it.opcode)
            OP_CHAR: begin
                chars.push_back(it.number[7:0]);
            end
            OP_OCT, OP_HEX_LO, OP_HEX_UP: begin
                base = (it.opcode == OP_OCT) ? 8 : 16;
                upper = (it.opcode == OP_HEX_UP);
                do begin
                    digits.push_front(upper ? UPPER_GLYPHS[int'(v % base)]
                                            : LOWER_GLYPHS[int'(v % base)]);
                    v = v / base;
                end while (v != 0);
                if (digits.size() < prec) begin
                    repeat (prec - digits.size()) chars.push_back(ASC_ZERO);
                end else if (it.opcode == OP_OCT) begin
                    chars.push_back(ASC_ZERO);
                end
                foreach (digits[k]) chars.push_back(digits[k]);
            end
            default: begin
                neg = it.twos_comp && (it.is_wide ? v[63] : v[31]);
                if (neg) begin
                    v = it.is_wide ? (~v + 64'd1) : {32'd0, ~v[31:0] + 32'd1};
                end
                do begin
                    digits.push_front(LOWER_GLYPHS[int'(v % 10)]);
                    v = v / 10;
                end while (v != 0);
                if (neg) begin
                    chars.push_back(ASC_MINUS);
                end
                if (digits.size() < prec) begin
                    repeat (prec - digits.size()) chars.push_back(ASC_ZERO);
                end
                foreach (digits[k]) chars.push_back(digits[k]);
            end
        endcase
    endfunction

    function automatic number_item_t random_number();
        number_item_t it;
        it.is_wide   = 1'($urandom_range(0, 1));
        it.twos_comp = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            it.opcode = 3'($urandom_range(int'(OP_UNDEF_LO), int'(OP_UNDEF_HI)));
        end else begin
            it.opcode = 3'($urandom_range(int'(OP_CHAR), int'(OP_HEX_UP)));
        end
        case ($urandom_range(0, 4))
            0: it.number = {$urandom, $urandom};
            1: it.number = 64'($urandom_range(0, 20));
            2: begin
                case ($urandom_range(0, 4))
                    0: it.number = '1;
                    1: it.number = 64'h8000_0000_0000_0000;
                    2: it.number = 64'h7FFF_FFFF_FFFF_FFFF;
                    3: it.number = {$urandom, 32'h8000_0000};
                    default: it.number = {$urandom, 32'h7FFF_FFFF};
                endcase
            end
            3: it.number = 64'd0 - 64'($urandom_range(1, 1000));
            default: it.number = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            it.min_digits = 6'($urandom_range(0, 63));
        end else begin
            it.min_digits = 6'($urandom_range(0, 8));
        end
        return it;
    endfunction

    task automatic add_row(input logic [63:0] number, input logic wide, input logic sgn,
                           input logic [2:0] op, input logic [5:0] prec, input string text);
        number_item_t it;
        it.number     = number;
        it.is_wide    = wide;
        it.twos_comp  = sgn;
        it.opcode     = op;
        it.min_digits = prec;
        table_items.push_back(it);
        table_text.push_back(text);
    endtask

    // an empty text means the characters come from format_number
    task automatic send_number(input number_item_t it, input string text);
        logic [7:0] chars[$];
        char_item_t rec;
        int k;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_number     <= it.number;
        s_is_wide    <= it.is_wide;
        s_twos_comp  <= it.twos_comp;
        s_opcode     <= it.opcode;
        s_min_digits <= it.min_digits;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (text.len() == 0) begin
            format_number(it, chars);
        end else begin
            chars = {};
            for (k = 0; k < text.len(); k++) chars.push_back(text[k]);
        end
        for (k = 0; k < chars.size(); k++) begin
            rec.char_code    = chars[k];
            rec.total_length = 6'(chars.size());
            rec.last         = (k == chars.size() - 1);
            pending_chars.push_back(rec);
        end
    endtask

    // result checking and receiver readiness, with the long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected item: char_code %0h total_length %0d last %0b",
                       m_char_code, m_total_length, m_last);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (m_char_code !== want.char_code) begin
                    $error("char_code expected %0h got %0h", want.char_code, m_char_code);
                    mismatches++;
                end
                if (m_total_length !== want.total_length) begin
                    $error("total_length expected %0d got %0d",
                           want.total_length, m_total_length);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last expected %0b got %0b", want.last, m_last);
                    mismatches++;
                end
            end
        end
        if (holdoff_seen != holdoff_request) begin
            holdoff_seen = holdoff_request;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        add_row(64'h41, 1'b0, 1'b0, OP_CHAR, 6'd0, "A");
        add_row(64'hFFFF_FFFF_FFFF_FF7E, 1'b0, 1'b1, OP_CHAR, 6'd40, "~");
        add_row(64'h0, 1'b1, 1'b0, OP_CHAR, 6'd0, "");
        add_row(64'hFF, 1'b1, 1'b1, OP_CHAR, 6'd63, "");
        add_row(64'h0, 1'b0, 1'b0, OP_DEC, 6'd0, "0");
        add_row(64'hFFFF_FFFF, 1'b0, 1'b0, OP_DEC, 6'd0, "4294967295");
        add_row(64'hFFFF_FFFF, 1'b0, 1'b1, OP_DEC, 6'd1, "-1");
        add_row(64'hABCD_0123_8000_0000, 1'b0, 1'b1, OP_DEC, 6'd0, "-2147483648");
        add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, OP_DEC, 6'd0, "-9223372036854775808");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, OP_DEC, 6'd0, "18446744073709551615");
        add_row(64'hFFFF_FFFB, 1'b0, 1'b1, OP_DEC, 6'd4, "-0005");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, OP_DEC, 6'd40, "");
        add_row(64'h5, 1'b0, 1'b0, OP_DEC, 6'd63, "");
        add_row(64'h0, 1'b0, 1'b0, OP_OCT, 6'd0, "00");
        add_row(64'h8, 1'b0, 1'b0, OP_OCT, 6'd0, "010");
        add_row(64'h8, 1'b0, 1'b0, OP_OCT, 6'd4, "0010");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, OP_OCT, 6'd0, "");
        add_row(64'hFFFF_FFFF, 1'b0, 1'b1, OP_OCT, 6'd0, "037777777777");
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, OP_HEX_LO, 6'd0, "ffffffffffffffff");
        add_row(64'h1234_5678_DEAD_BEEF, 1'b0, 1'b1, OP_HEX_UP, 6'd0, "DEADBEEF");
        add_row(64'h0, 1'b1, 1'b0, OP_HEX_LO, 6'd0, "0");
        add_row(64'hAB, 1'b0, 1'b0, OP_HEX_UP, 6'd50, "");
        add_row(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 1'b1, OP_UNDEF_LO, 6'd3, "");
        add_row(64'h0000_0000_8000_0001, 1'b0, 1'b1, OP_UNDEF_HI, 6'd12, "");

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (table_items[r]) send_number(table_items[r], table_text[r]);
        repeat (RANDOM_PER_PHASE) send_number(random_number(), "");

        sender_idle_pct   = 76;
        receiver_idle_pct = 20;
        repeat (RANDOM_PER_PHASE) send_number(random_number(), "");

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        holdoff_request++;
        repeat (RANDOM_PER_PHASE) send_number(random_number(), "");
        s_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
